/* design/itrgb_pkg.sv */
// Package for the iteration-count to RGB palette block.
// Shared constants, register indexes, rotation codes and pipeline control type.
// No dependencies.
`default_nettype none

package itrgb_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int LIMIT_WIDTH     = 16;
  localparam int ROT_WIDTH       = 3;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int COLOR_WIDTH     = 8;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd64;
  localparam logic [ROT_WIDTH-1:0]   ROT_RESET   = 3'd0;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PALETTE_ROTATION = 1'b1;

  // term weight times 255
  localparam int            K_WIDTH    = 12;
  localparam logic [11:0]   KA_SCALED  = 12'd2295;
  localparam logic [11:0]   KB_SCALED  = 12'd3825;
  localparam int            TERM_WIDTH = K_WIDTH;

  localparam logic [COLOR_WIDTH-1:0] COLOR_MAX = 8'hFF;

  // channel order red/green/blue for each rotation setting
  localparam logic [ROT_WIDTH-1:0] ROT_ABC     = 3'd0;
  localparam logic [ROT_WIDTH-1:0] ROT_CAB     = 3'd1;
  localparam logic [ROT_WIDTH-1:0] ROT_BCA     = 3'd2;
  localparam logic [ROT_WIDTH-1:0] ROT_CBA     = 3'd3;
  localparam logic [ROT_WIDTH-1:0] ROT_ACB     = 3'd4;
  localparam logic [ROT_WIDTH-1:0] ROT_BAC     = 3'd5;
  localparam logic [ROT_WIDTH-1:0] ROT_CBA_ALT = 3'd6;
  localparam logic [ROT_WIDTH-1:0] ROT_ACB_ALT = 3'd7;

  typedef struct packed {
    logic valid;
    logic black;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* design/itrgb_div.sv */
// Pipelined restoring divider: t = (count << FRACTION_BITS) / limit, one bit per stage.
// Requires count < limit. Uses itrgb_pkg.
`default_nettype none

module itrgb_div #(
  parameter int COUNT_WIDTH   = itrgb_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = itrgb_pkg::FRACTION_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  itrgb_pkg::stage_ctl_t     ctl_i,
  input  wire  [COUNT_WIDTH-1:0]    count_i,
  input  wire  [COUNT_WIDTH-1:0]    limit_i,
  output itrgb_pkg::stage_ctl_t     ctl_o,
  output logic [FRACTION_BITS-1:0]  quot_o
);

  itrgb_pkg::stage_ctl_t     ctl_q   [FRACTION_BITS];
  itrgb_pkg::stage_ctl_t     ctl_in  [FRACTION_BITS];
  logic [COUNT_WIDTH-1:0]    rem_in  [FRACTION_BITS];
  logic [COUNT_WIDTH-1:0]    rem_d   [FRACTION_BITS];
  logic [COUNT_WIDTH-1:0]    rem_q   [FRACTION_BITS];
  logic [FRACTION_BITS-1:0]  quot_in [FRACTION_BITS];
  logic [FRACTION_BITS-1:0]  quot_d  [FRACTION_BITS];
  logic [FRACTION_BITS-1:0]  quot_q  [FRACTION_BITS];

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
    logic [COUNT_WIDTH:0] dbl;
    logic [COUNT_WIDTH:0] diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign ctl_in[k]  = ctl_i;
      assign rem_in[k]  = count_i;
      assign quot_in[k] = '0;
    end else begin : g_next
      assign ctl_in[k]  = ctl_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign quot_in[k] = quot_q[k-1];
    end

    assign dbl       = {rem_in[k], 1'b0};
    assign diff      = dbl - {1'b0, limit_i};
    assign ge        = (dbl >= {1'b0, limit_i});
    assign rem_d[k]  = ge ? diff[COUNT_WIDTH-1:0] : dbl[COUNT_WIDTH-1:0];
    assign quot_d[k] = {quot_in[k][FRACTION_BITS-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
      end
    end
  end

  assign ctl_o  = ctl_q[FRACTION_BITS-1];
  assign quot_o = quot_q[FRACTION_BITS-1];

endmodule

`default_nettype wire

/* design/itrgb_poly.sv */
// Bernstein term pipeline: powers of t and u = 1 - t, then the three scaled terms.
// Five register stages, terms left unsaturated. Uses itrgb_pkg.
`default_nettype none

module itrgb_poly #(
  parameter int FRACTION_BITS = itrgb_pkg::FRACTION_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  itrgb_pkg::stage_ctl_t                ctl_i,
  input  wire  [FRACTION_BITS-1:0]             t_i,
  output itrgb_pkg::stage_ctl_t                ctl_o,
  output logic [itrgb_pkg::TERM_WIDTH-1:0]     term_a_o,
  output logic [itrgb_pkg::TERM_WIDTH-1:0]     term_b_o,
  output logic [itrgb_pkg::TERM_WIDTH-1:0]     term_c_o
);

  localparam int FB     = FRACTION_BITS;
  localparam int KW     = itrgb_pkg::K_WIDTH;
  localparam int QW     = FB + KW;
  localparam int VW     = 2 * FB + KW;
  localparam int STAGES = 5;

  itrgb_pkg::stage_ctl_t ctl_q [STAGES];

  logic [FB-1:0]   s1_t_q, s1_u_q, s1_u_d;
  logic [2*FB-1:0] s2_tt, s2_uu;
  logic [FB-1:0]   s2_t_q, s2_u_q, s2_t2_q, s2_u2_q;
  logic [2*FB-1:0] s3_ttt, s3_uuu;
  logic [FB-1:0]   s3_t_q, s3_u_q, s3_t2_q, s3_u2_q, s3_t3_q, s3_u3_q;
  logic [QW-1:0]   s4_qa_d, s4_qb_d, s4_qc_d;
  logic [QW-1:0]   s4_qa_q, s4_qb_q, s4_qc_q;
  logic [FB-1:0]   s4_pa_q, s4_pb_q, s4_pc_q;
  logic [VW-1:0]   s5_va, s5_vb, s5_vc;
  logic [KW-1:0]   s5_a_q, s5_b_q, s5_c_q;

  // t is nonzero on every item that is not forced black
  assign s1_u_d = {FB{1'b0}} - t_i;
  assign s2_tt  = (2*FB)'(s1_t_q) * (2*FB)'(s1_t_q);
  assign s2_uu  = (2*FB)'(s1_u_q) * (2*FB)'(s1_u_q);
  assign s3_ttt = (2*FB)'(s2_t2_q) * (2*FB)'(s2_t_q);
  assign s3_uuu = (2*FB)'(s2_u2_q) * (2*FB)'(s2_u_q);
  assign s4_qa_d = QW'(s3_t3_q) * QW'(itrgb_pkg::KA_SCALED);
  assign s4_qb_d = QW'(s3_t2_q) * QW'(itrgb_pkg::KB_SCALED);
  assign s4_qc_d = QW'(s3_t_q)  * QW'(itrgb_pkg::KA_SCALED);
  assign s5_va  = VW'(s4_pa_q) * VW'(s4_qa_q);
  assign s5_vb  = VW'(s4_pb_q) * VW'(s4_qb_q);
  assign s5_vc  = VW'(s4_pc_q) * VW'(s4_qc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_t_q  <= t_i;
      s1_u_q  <= s1_u_d;
      s2_t_q  <= s1_t_q;
      s2_u_q  <= s1_u_q;
      s2_t2_q <= s2_tt[2*FB-1:FB];
      s2_u2_q <= s2_uu[2*FB-1:FB];
      s3_t_q  <= s2_t_q;
      s3_u_q  <= s2_u_q;
      s3_t2_q <= s2_t2_q;
      s3_u2_q <= s2_u2_q;
      s3_t3_q <= s3_ttt[2*FB-1:FB];
      s3_u3_q <= s3_uuu[2*FB-1:FB];
      s4_qa_q <= s4_qa_d;
      s4_qb_q <= s4_qb_d;
      s4_qc_q <= s4_qc_d;
      s4_pa_q <= s3_u_q;
      s4_pb_q <= s3_u2_q;
      s4_pc_q <= s3_u3_q;
      s5_a_q  <= s5_va[VW-1:2*FB];
      s5_b_q  <= s5_vb[VW-1:2*FB];
      s5_c_q  <= s5_vc[VW-1:2*FB];
    end
  end

  assign ctl_o    = ctl_q[STAGES-1];
  assign term_a_o = s5_a_q;
  assign term_b_o = s5_b_q;
  assign term_c_o = s5_c_q;

endmodule

`default_nettype wire

/* design/iteration_to_rgb_palette_top.sv */
// Top level of the iteration-count to RGB palette block.
// Holds the configuration registers, input and output stages. Uses itrgb_pkg,
// itrgb_div and itrgb_poly.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with iteration_count_i, one pixel per item.
//   Output channel: out_valid_o / out_stall_i with red_o, green_o, blue_o.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0: iteration limit, 1: palette rotation); write only while idle.
//   Throughput: one item per cycle while the output is not stalled.
//   Path: input register, the divider (one quotient bit per stage), the five
//   register stages of the term pipeline, then the output register.
//   Reset: all valid bits clear, limit returns to 64 and rotation to 0.
//   Stall: while a result is held on a stalled output, the whole pipeline
//   freezes and in_stall_o is raised; nothing is dropped or repeated.
`default_nettype none

module iteration_to_rgb_palette_top #(
  parameter int COUNT_WIDTH   = itrgb_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = itrgb_pkg::FRACTION_BITS_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire  [itrgb_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  wire  [itrgb_pkg::CFG_DATA_WIDTH-1:0]     cfg_data_i,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire  [15:0]                              iteration_count_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output logic [itrgb_pkg::COLOR_WIDTH-1:0]        red_o,
  output logic [itrgb_pkg::COLOR_WIDTH-1:0]        green_o,
  output logic [itrgb_pkg::COLOR_WIDTH-1:0]        blue_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int TW = itrgb_pkg::TERM_WIDTH;
  localparam int OW = itrgb_pkg::COLOR_WIDTH;

  logic [itrgb_pkg::LIMIT_WIDTH-1:0] limit_q;
  logic [itrgb_pkg::ROT_WIDTH-1:0]   rot_q;

  logic                  en;
  logic [CW-1:0]         count_d, lim, lim_eff;
  itrgb_pkg::stage_ctl_t in_ctl_d, in_ctl_q;
  logic [CW-1:0]         in_count_q;

  itrgb_pkg::stage_ctl_t div_ctl, poly_ctl;
  logic [FRACTION_BITS-1:0] div_t;
  logic [TW-1:0]         term_a, term_b, term_c;
  logic [OW-1:0]         sat_a, sat_b, sat_c;
  logic [OW-1:0]         red_d, green_d, blue_d;
  logic                  out_valid_q;
  logic [OW-1:0]         red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= itrgb_pkg::LIMIT_RESET;
      rot_q   <= itrgb_pkg::ROT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        itrgb_pkg::REG_ITERATION_LIMIT: begin
          limit_q <= cfg_data_i[itrgb_pkg::LIMIT_WIDTH-1:0];
        end
        itrgb_pkg::REG_PALETTE_ROTATION: begin
          rot_q <= cfg_data_i[itrgb_pkg::ROT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // zero limit acts as one; zero count or count at/above limit gives black
  assign count_d        = CW'(iteration_count_i);
  assign lim            = CW'(limit_q);
  assign lim_eff        = (lim == '0) ? CW'(1) : lim;
  assign in_ctl_d.valid = in_valid_i;
  assign in_ctl_d.black = (count_d == '0) || (count_d >= lim_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else if (en) begin
      in_ctl_q <= in_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_count_q <= count_d;
    end
  end

  itrgb_div #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (in_ctl_q),
    .count_i (in_count_q),
    .limit_i (lim_eff),
    .ctl_o   (div_ctl),
    .quot_o  (div_t)
  );

  itrgb_poly #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (div_ctl),
    .t_i      (div_t),
    .ctl_o    (poly_ctl),
    .term_a_o (term_a),
    .term_b_o (term_b),
    .term_c_o (term_c)
  );

  assign sat_a = (term_a > TW'(itrgb_pkg::COLOR_MAX)) ? itrgb_pkg::COLOR_MAX : term_a[OW-1:0];
  assign sat_b = (term_b > TW'(itrgb_pkg::COLOR_MAX)) ? itrgb_pkg::COLOR_MAX : term_b[OW-1:0];
  assign sat_c = (term_c > TW'(itrgb_pkg::COLOR_MAX)) ? itrgb_pkg::COLOR_MAX : term_c[OW-1:0];

  always_comb begin
    red_d   = sat_a;
    green_d = sat_b;
    blue_d  = sat_c;
    case (rot_q) inside
      itrgb_pkg::ROT_ABC: begin
        red_d = sat_a; green_d = sat_b; blue_d = sat_c;
      end
      itrgb_pkg::ROT_CAB: begin
        red_d = sat_c; green_d = sat_a; blue_d = sat_b;
      end
      itrgb_pkg::ROT_BCA: begin
        red_d = sat_b; green_d = sat_c; blue_d = sat_a;
      end
      itrgb_pkg::ROT_CBA, itrgb_pkg::ROT_CBA_ALT: begin
        red_d = sat_c; green_d = sat_b; blue_d = sat_a;
      end
      itrgb_pkg::ROT_ACB, itrgb_pkg::ROT_ACB_ALT: begin
        red_d = sat_a; green_d = sat_c; blue_d = sat_b;
      end
      itrgb_pkg::ROT_BAC: begin
        red_d = sat_b; green_d = sat_a; blue_d = sat_c;
      end
      default: begin
        red_d = sat_a; green_d = sat_b; blue_d = sat_c;
      end
    endcase
    if (poly_ctl.black) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= poly_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

/* design/itrgb_checker.sv */
// Port-level checks for iteration_to_rgb_palette_top, attached by bind.
// Uses itrgb_pkg.
`default_nettype none

module itrgb_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_stall_o,
  input wire                                out_valid_o,
  input wire                                out_stall_i,
  input wire [itrgb_pkg::COLOR_WIDTH-1:0]   red_o,
  input wire [itrgb_pkg::COLOR_WIDTH-1:0]   green_o,
  input wire [itrgb_pkg::COLOR_WIDTH-1:0]   blue_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({red_o, green_o, blue_o}))
    else $error("stalled output item changed");

  // input backpressure only comes from a held output item
  a_in_stall_src: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output item");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output item presented during reset");

endmodule

bind iteration_to_rgb_palette_top itrgb_checker u_itrgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for iteration_to_rgb_palette_top: directed pixels, then random pixels
// over several limit/rotation settings and idle/stall patterns, checked against a local
// fixed-point palette predictor. Depends on itrgb_pkg and the design sources.
module tb;

  typedef struct packed {
    logic [itrgb_pkg::COLOR_WIDTH-1:0] red;
    logic [itrgb_pkg::COLOR_WIDTH-1:0] green;
    logic [itrgb_pkg::COLOR_WIDTH-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [15:0] count;
    logic        known;
    rgb_t        color;
  } pixel_row_t;

  localparam int   FB          = itrgb_pkg::FRACTION_BITS_DEF;
  localparam int   LATENCY     = itrgb_pkg::FRACTION_BITS_DEF + 7;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   N_PHASES    = 12;
  localparam int   PHASE_ITEMS = 95;
  localparam int   N_DIRECTED  = 18;
  localparam rgb_t BLACK       = '0;

  // reset config: limit 64, rotation 0
  localparam pixel_row_t DIRECTED [N_DIRECTED] = '{
    '{16'd0,     1'b1, BLACK},
    '{16'd64,    1'b1, BLACK},
    '{16'd65,    1'b1, BLACK},
    '{16'hFFFF,  1'b1, BLACK},
    '{16'h8000,  1'b1, BLACK},
    '{16'h5555,  1'b1, BLACK},
    '{16'hAAAA,  1'b1, BLACK},
    '{16'd1,     1'b0, BLACK},
    '{16'd2,     1'b0, BLACK},
    '{16'd8,     1'b0, BLACK},
    '{16'd16,    1'b0, BLACK},
    '{16'd21,    1'b0, BLACK},
    '{16'd32,    1'b0, BLACK},
    '{16'd43,    1'b0, BLACK},
    '{16'd48,    1'b0, BLACK},
    '{16'd56,    1'b0, BLACK},
    '{16'd62,    1'b0, BLACK},
    '{16'd63,    1'b0, BLACK}
  };

  logic                                  clk_i             = 1'b0;
  logic                                  rst_ni            = 1'b0;
  logic                                  cfg_we_i          = 1'b0;
  logic [itrgb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i       = '0;
  logic [itrgb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i        = '0;
  logic                                  in_valid_i        = 1'b0;
  logic [15:0]                           iteration_count_i = '0;
  logic                                  out_stall_i       = 1'b0;
  wire                                   in_stall_o;
  wire                                   out_valid_o;
  wire  [itrgb_pkg::COLOR_WIDTH-1:0]     red_o;
  wire  [itrgb_pkg::COLOR_WIDTH-1:0]     green_o;
  wire  [itrgb_pkg::COLOR_WIDTH-1:0]     blue_o;

  logic [itrgb_pkg::LIMIT_WIDTH-1:0] cur_limit    = itrgb_pkg::LIMIT_RESET;
  logic [itrgb_pkg::ROT_WIDTH-1:0]   cur_rotation = itrgb_pkg::ROT_RESET;
  rgb_t pending_colors [$];
  int   errors        = 0;
  int   pixels_sent   = 0;
  int   colors_seen   = 0;
  int   cfg_writes    = 0;
  int   cycles        = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;

  always #10 clk_i = ~clk_i;

  iteration_to_rgb_palette_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .iteration_count_i (iteration_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o)
  );

  function automatic logic [7:0] bern_term(bit [63:0] k, bit [63:0] p, bit [63:0] q);
    bit [63:0] v;
    v = (k * p * q) >> (2 * FB);
    return (v > 64'd255) ? itrgb_pkg::COLOR_MAX : v[7:0];
  endfunction

  function automatic rgb_t palette_color(logic [15:0] cnt,
                                         logic [itrgb_pkg::LIMIT_WIDTH-1:0] lim,
                                         logic [itrgb_pkg::ROT_WIDTH-1:0] rot);
    bit [63:0]  c, l, one, t, u, t2, t3, u2, u3;
    logic [7:0] term [3];
    logic [7:0] ch [3];
    bit         mirror;
    int         r;
    rgb_t       res;
    one = 64'd1 << FB;
    l = (lim == 0) ? 64'd1 : 64'(lim);
    c = 64'(cnt);
    if (c > l) c = l;
    t = (c << FB) / l;
    if (t > one) t = one;
    u  = one - t;
    t2 = (t * t) >> FB;
    t3 = (t2 * t) >> FB;
    u2 = (u * u) >> FB;
    u3 = (u2 * u) >> FB;
    term[0] = bern_term(64'(itrgb_pkg::KA_SCALED), u, t3);
    term[1] = bern_term(64'(itrgb_pkg::KB_SCALED), u2, t2);
    term[2] = bern_term(64'(itrgb_pkg::KA_SCALED), u3, t);
    mirror = (rot >= itrgb_pkg::ROT_CBA);
    r = (mirror ? int'(rot) - 3 : int'(rot)) % 3;
    for (int j = 0; j < 3; j++)
      ch[(r + j) % 3] = term[mirror ? 2 - j : j];
    res.red   = ch[0];
    res.green = ch[1];
    res.blue  = ch[2];
    return res;
  endfunction

  function automatic logic [15:0] next_count(logic [itrgb_pkg::LIMIT_WIDTH-1:0] lim_reg);
    int lim;
    int sel;
    lim = (lim_reg == 0) ? 1 : int'(lim_reg);
    sel = $urandom_range(99);
    if (sel < 65) return 16'($urandom_range(lim, 0));
    if (sel < 80) begin
      case ($urandom_range(3))
        0: return 16'd0;
        1: return 16'(lim);
        2: return 16'(lim - 1);
        default: return 16'd1;
      endcase
    end
    if (sel < 90) return (lim < 65535) ? 16'($urandom_range(65535, lim + 1)) : 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic void check_channel(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic send_pixel(input logic [15:0] c, input rgb_t color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    iteration_count_i <= c;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_colors.push_back(color);
    pixels_sent++;
  endtask

  task automatic wait_drain();
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [itrgb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [itrgb_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == itrgb_pkg::REG_ITERATION_LIMIT) cur_limit = data[itrgb_pkg::LIMIT_WIDTH-1:0];
    else cur_rotation = data[itrgb_pkg::ROT_WIDTH-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      colors_seen++;
      if (pending_colors.size() == 0) begin
        errors++;
        $display("%0t: unexpected color, expected none, got %0d/%0d/%0d",
                 $time, red_o, green_o, blue_o);
      end else begin
        want = pending_colors.pop_front();
        check_channel("red", want.red, red_o);
        check_channel("green", want.green, green_o);
        check_channel("blue", want.blue, blue_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d colors outstanding",
               cycles, pending_colors.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [itrgb_pkg::LIMIT_WIDTH-1:0] phase_limit [N_PHASES];
    logic [itrgb_pkg::ROT_WIDTH-1:0]   phase_rot [N_PHASES];
    logic [12:0]                       junk;
    logic [15:0]                       c;
    phase_limit = '{16'd1, 16'd65535, 16'd0, 16'd100, 16'd7, 16'd1000,
                    16'd65535, 16'd3, 16'd0, 16'd255, 16'd0, 16'd0};
    phase_rot   = '{itrgb_pkg::ROT_ABC, itrgb_pkg::ROT_CAB, itrgb_pkg::ROT_BCA,
                    itrgb_pkg::ROT_CBA, itrgb_pkg::ROT_ACB, itrgb_pkg::ROT_BAC,
                    itrgb_pkg::ROT_CBA_ALT, itrgb_pkg::ROT_ACB_ALT, itrgb_pkg::ROT_ABC,
                    itrgb_pkg::ROT_ABC, itrgb_pkg::ROT_ABC, itrgb_pkg::ROT_ABC};
    phase_limit[8]  = 16'($urandom_range(65535, 1));
    phase_limit[10] = 16'($urandom_range(5000, 1));
    phase_limit[11] = 16'($urandom_range(40, 2));
    phase_rot[8]    = 3'($urandom_range(7));
    phase_rot[10]   = 3'($urandom_range(7));
    phase_rot[11]   = 3'($urandom_range(7));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(DIRECTED[i].count, DIRECTED[i].known ? DIRECTED[i].color :
                 palette_color(DIRECTED[i].count, cur_limit, cur_rotation));
    in_valid_i <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      junk = 13'($urandom_range(8191));
      write_reg(itrgb_pkg::REG_ITERATION_LIMIT, phase_limit[p]);
      write_reg(itrgb_pkg::REG_PALETTE_ROTATION, {junk, phase_rot[p]});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        c = next_count(cur_limit);
        send_pixel(c, palette_color(c, cur_limit, cur_rotation));
      end
      in_valid_i <= 1'b0;
    end

    wait_drain();
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("tb: %0d pixels sent, %0d colors checked, %0d register writes",
             pixels_sent, colors_seen, cfg_writes);
    $display("tb: %0d palette settings incl. limits 0/1/65535 and rotations 0..7, %0d errors",
             N_PHASES + 1, errors);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* iteration_to_rgb_palette_top.f */
design/itrgb_pkg.sv
design/itrgb_div.sv
design/itrgb_poly.sv
design/iteration_to_rgb_palette_top.sv
design/itrgb_checker.sv
verif/tb.sv
